/* rtl/core/biu_pkg.sv */
// ---------------------------------------------------------------------------
// biu_pkg
// shared constants, types and reciprocal tables of the bilinear upscaler
// ---------------------------------------------------------------------------
package biu_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_ZOOM   = 8;

	localparam int PIX_W     = 8;
	localparam int SRC_W     = 8;
	localparam int COORD_W   = 11;
	localparam int ZOOM_W    = 4;
	localparam int DIM_W     = 13;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ZOOM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;

	// ceil(2^16 / z) and ceil(2^24 / z^2)
	localparam int RCP_SHIFT  = 16;
	localparam int RCP_W      = 17;
	localparam int RCP2_SHIFT = 24;
	localparam int RCP2_W     = 25;

	typedef struct packed {
		logic               valid;
		logic               cmd;
		logic [SRC_W-1:0]   src_row;
		logic [SRC_W-1:0]   src_col;
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
	} item_t;

	// request context handed from address stage to blend stages
	typedef struct packed {
		logic              valid;
		logic              err;
		logic [ZOOM_W-1:0] z;
		logic [ZOOM_W-1:0] fy;
		logic [ZOOM_W-1:0] fx;
		logic              y0_odd;
		logic              x0_odd;
		logic              y_clamp;
		logic              x_clamp;
	} tag_t;

	function automatic logic [RCP_W-1:0] recip_z(input logic [ZOOM_W-1:0] z);
		logic [RCP_W-1:0] r;
		case (z)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			4'd10:   r = 17'd6554;
			4'd11:   r = 17'd5958;
			4'd12:   r = 17'd5462;
			4'd13:   r = 17'd5042;
			4'd14:   r = 17'd4682;
			4'd15:   r = 17'd4370;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	function automatic logic [RCP2_W-1:0] recip_zz(input logic [ZOOM_W-1:0] z);
		logic [RCP2_W-1:0] r;
		case (z)
			4'd1:    r = 25'd16777216;
			4'd2:    r = 25'd4194304;
			4'd3:    r = 25'd1864136;
			4'd4:    r = 25'd1048576;
			4'd5:    r = 25'd671089;
			4'd6:    r = 25'd466034;
			4'd7:    r = 25'd342393;
			4'd8:    r = 25'd262144;
			4'd9:    r = 25'd207127;
			4'd10:   r = 25'd167773;
			4'd11:   r = 25'd138655;
			4'd12:   r = 25'd116509;
			4'd13:   r = 25'd99274;
			4'd14:   r = 25'd85599;
			4'd15:   r = 25'd74566;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/biu_if.sv */
// ---------------------------------------------------------------------------
// biu request and response channels
// valid/ready channels carrying one word each
// ---------------------------------------------------------------------------
interface biu_req_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [biu_pkg::SRC_W-1:0]   src_row;
	logic [biu_pkg::SRC_W-1:0]   src_col;
	logic [biu_pkg::PIX_W-1:0]   pixel_in;
	logic [biu_pkg::COORD_W-1:0] out_row;
	logic [biu_pkg::COORD_W-1:0] out_col;

	modport source(output valid, cmd, src_row, src_col, pixel_in, out_row, out_col,
		input ready);
	modport sink(input valid, cmd, src_row, src_col, pixel_in, out_row, out_col,
		output ready);
endinterface

interface biu_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [biu_pkg::PIX_W-1:0] pixel_out;
	logic                      range_error;

	modport source(output valid, pixel_out, range_error, input ready);
	modport sink(input valid, pixel_out, range_error, output ready);
endinterface

/* rtl/core/biu_ram.sv */
// ---------------------------------------------------------------------------
// biu_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module biu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/biu_coord.sv */
// ---------------------------------------------------------------------------
// biu_coord
// divides output coordinates by zoom, range check, bank addressing and load writes
// ---------------------------------------------------------------------------
module biu_coord #(
	parameter int MAX_WIDTH  = biu_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = biu_pkg::MAX_HEIGHT,
	parameter int ROW_W      = 8,
	parameter int COL_W      = 8,
	parameter int BANK_AW    = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  biu_pkg::item_t                    item_s1,
	input  logic [biu_pkg::ZOOM_W-1:0]        zoom,
	input  logic [biu_pkg::DIM_W-1:0]         cols,
	input  logic [biu_pkg::DIM_W-1:0]         rows,
	output logic [3:0][BANK_AW-1:0]           rd_addr,
	output logic [3:0]                        wr_en,
	output logic [BANK_AW-1:0]                wr_addr,
	output logic [biu_pkg::PIX_W-1:0]         wr_data,
	output biu_pkg::tag_t                     tag
);

	localparam int CW = biu_pkg::COORD_W;
	localparam int LW = biu_pkg::DIM_W + biu_pkg::ZOOM_W;
	localparam logic [biu_pkg::DIM_W-1:0] WMAX = biu_pkg::DIM_W'(MAX_WIDTH);
	localparam logic [biu_pkg::DIM_W-1:0] HMAX = biu_pkg::DIM_W'(MAX_HEIGHT);

	logic [biu_pkg::RCP_W-1:0]    rcp;
	logic [CW+biu_pkg::RCP_W-1:0] prod_r, prod_c;
	logic [LW-1:0]                lim_r, lim_c;
	logic                         err, load_ok;

	logic                         v_s2, cmd_s2, err_s2, load_ok_s2;
	logic [CW-1:0]                y0_s2, x0_s2, orow_s2, ocol_s2;
	logic [biu_pkg::SRC_W-1:0]    srow_s2, scol_s2;
	logic [biu_pkg::PIX_W-1:0]    pix_s2;

	logic [CW+biu_pkg::ZOOM_W-1:0] ry, rx;
	logic [CW-1:0]                 dy, dx;
	logic [biu_pkg::DIM_W-1:0]     yn, xn;
	logic [11:0]                   yr, yr_n, xr, xr_n, lr, lc, ysel, xsel;

	// reciprocal multiply gives exact quotients for these coordinate widths
	always_comb begin
		rcp     = biu_pkg::recip_z(zoom);
		prod_r  = item_s1.out_row * rcp;
		prod_c  = item_s1.out_col * rcp;
		lim_r   = rows * zoom;
		lim_c   = cols * zoom;
		err     = (LW'(item_s1.out_row) >= lim_r) || (LW'(item_s1.out_col) >= lim_c);
		load_ok = (biu_pkg::DIM_W'(item_s1.src_row) < HMAX)
			&& (biu_pkg::DIM_W'(item_s1.src_col) < WMAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2     <= item_s1.cmd;
			err_s2     <= err;
			load_ok_s2 <= load_ok;
			y0_s2      <= prod_r[biu_pkg::RCP_SHIFT +: CW];
			x0_s2      <= prod_c[biu_pkg::RCP_SHIFT +: CW];
			orow_s2    <= item_s1.out_row;
			ocol_s2    <= item_s1.out_col;
			srow_s2    <= item_s1.src_row;
			scol_s2    <= item_s1.src_col;
			pix_s2     <= item_s1.pixel;
		end
	end

	always_comb begin
		ry   = y0_s2 * zoom;
		rx   = x0_s2 * zoom;
		dy   = orow_s2 - ry[CW-1:0];
		dx   = ocol_s2 - rx[CW-1:0];
		yn   = biu_pkg::DIM_W'(y0_s2) + 1'b1;
		xn   = biu_pkg::DIM_W'(x0_s2) + 1'b1;
		yr   = 12'(y0_s2);
		xr   = 12'(x0_s2);
		yr_n = yr + 1'b1;
		xr_n = xr + 1'b1;
		lr   = 12'(srow_s2);
		lc   = 12'(scol_s2);
		for (int b = 0; b < 4; b++) begin
			// row y0 and y0+1 always sit in banks of opposite parity
			ysel       = (yr[0] == b[1]) ? yr : yr_n;
			xsel       = (xr[0] == b[0]) ? xr : xr_n;
			rd_addr[b] = {ysel[ROW_W-1:1], xsel[COL_W-1:1]};
			wr_en[b]   = adv && v_s2 && (cmd_s2 == biu_pkg::CMD_LOAD) && load_ok_s2
				&& ({srow_s2[0], scol_s2[0]} == 2'(b));
		end
		wr_addr = {lr[ROW_W-1:1], lc[COL_W-1:1]};
		wr_data = pix_s2;

		tag.valid   = v_s2 && (cmd_s2 == biu_pkg::CMD_READ);
		tag.err     = err_s2;
		tag.z       = zoom;
		tag.fy      = dy[biu_pkg::ZOOM_W-1:0];
		tag.fx      = dx[biu_pkg::ZOOM_W-1:0];
		tag.y0_odd  = y0_s2[0];
		tag.x0_odd  = x0_s2[0];
		tag.y_clamp = yn >= rows;
		tag.x_clamp = xn >= cols;
	end

endmodule

/* rtl/core/biu_blend.sv */
// ---------------------------------------------------------------------------
// biu_blend
// weights, 2x2 weighted sum and normalization by z squared
// ---------------------------------------------------------------------------
module biu_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  biu_pkg::tag_t                    tag,
	input  logic [3:0][biu_pkg::PIX_W-1:0]   bank_q,
	output logic                             out_valid,
	output logic [biu_pkg::PIX_W-1:0]        pixel_out,
	output logic                             range_error
);

	localparam int ZW = biu_pkg::ZOOM_W;
	localparam int PW = biu_pkg::PIX_W;
	localparam int WW = 2 * ZW;
	localparam int SW = 16;

	biu_pkg::tag_t   tag_s3;
	logic [ZW-1:0]   gy, gx;
	logic [1:0]      i00, i01, i10, i11;
	logic [PW-1:0]   p00, p01, p10, p11;

	logic            v_s4, err_s4;
	logic [ZW-1:0]   z_s4;
	logic [WW-1:0]   w00_s4, w01_s4, w10_s4, w11_s4;
	logic [PW-1:0]   p00_s4, p01_s4, p10_s4, p11_s4;
	logic [SW+1:0]   sum_full;

	logic            v_s5, err_s5;
	logic [ZW-1:0]   z_s5;
	logic [SW-1:0]   sum_s5;
	logic [SW+biu_pkg::RCP2_W-1:0] norm;

	logic            out_v_q, err_q;
	logic [PW-1:0]   pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3  <= '0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			tag_s3  <= tag;
			v_s4    <= tag_s3.valid;
			v_s5    <= v_s4;
			out_v_q <= v_s5;
		end
	end

	// neighbors past the last row or column reuse the clamped pixel
	always_comb begin
		gy  = tag_s3.z - tag_s3.fy;
		gx  = tag_s3.z - tag_s3.fx;
		i00 = {tag_s3.y0_odd, tag_s3.x0_odd};
		i01 = {tag_s3.y0_odd, ~tag_s3.x0_odd};
		i10 = {~tag_s3.y0_odd, tag_s3.x0_odd};
		i11 = {~tag_s3.y0_odd, ~tag_s3.x0_odd};
		p00 = bank_q[i00];
		p01 = tag_s3.x_clamp ? p00 : bank_q[i01];
		p10 = tag_s3.y_clamp ? p00 : bank_q[i10];
		if (tag_s3.y_clamp) begin
			p11 = p01;
		end else if (tag_s3.x_clamp) begin
			p11 = p10;
		end else begin
			p11 = bank_q[i11];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4 <= tag_s3.err;
			z_s4   <= tag_s3.z;
			w00_s4 <= gy * gx;
			w01_s4 <= gy * tag_s3.fx;
			w10_s4 <= tag_s3.fy * gx;
			w11_s4 <= tag_s3.fy * tag_s3.fx;
			p00_s4 <= p00;
			p01_s4 <= p01;
			p10_s4 <= p10;
			p11_s4 <= p11;
		end
	end

	assign sum_full = (SW+2)'(w00_s4) * (SW+2)'(p00_s4)
		+ (SW+2)'(w01_s4) * (SW+2)'(p01_s4)
		+ (SW+2)'(w10_s4) * (SW+2)'(p10_s4)
		+ (SW+2)'(w11_s4) * (SW+2)'(p11_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s5 <= err_s4;
			z_s5   <= z_s4;
			sum_s5 <= sum_full[SW-1:0];
		end
	end

	// floor(sum / z^2) by reciprocal multiply, exact for sums below 2^16
	assign norm = sum_s5 * biu_pkg::recip_zz(z_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			err_q <= err_s5;
			pix_q <= err_s5 ? '0 : norm[biu_pkg::RCP2_SHIFT +: PW];
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_out   = pix_q;
	assign range_error = err_q;

	a_weights_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !err_s4 |-> (10'(w00_s4) + 10'(w01_s4) + 10'(w10_s4) + 10'(w11_s4))
			== (10'(z_s4) * 10'(z_s4)))
		else $error("blend weights do not sum to z squared");

endmodule

/* rtl/core/bilinear_image_upscaler.sv */
// ---------------------------------------------------------------------------
// bilinear_image_upscaler
// integer zoom bilinear upscaler over a stored 8-bit grayscale image
// ---------------------------------------------------------------------------
// a response word leaves the output register after its request word passes the
//   input register and the address, ram read, weights, sum and norm stages
// throughput: one word per cycle unless the output stalls, loads and requests mixed freely
// the whole pipeline advances together; a stalled output freezes every stage
// reset clears valid bits and config (zoom 2, 256 x 256); image memory is not
//   cleared and needs no clearing pass
// ---------------------------------------------------------------------------
module bilinear_image_upscaler #(
	parameter int MAX_WIDTH  = biu_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = biu_pkg::MAX_HEIGHT,
	parameter int MAX_ZOOM   = biu_pkg::MAX_ZOOM
) (
	input  logic                            clk,
	input  logic                            arst_n,
	biu_req_if.sink                         req,
	biu_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [biu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [biu_pkg::CFG_W-1:0]       cfg_wdata
);

	// image split into four banks by row and column parity so that all four pixels
	// of the 2x2 neighborhood are read in the same cycle, one read per bank
	localparam int ROW_W      = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
	localparam int COL_W      = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
	localparam int BANK_AW    = ROW_W - 1 + COL_W - 1;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int DW         = biu_pkg::DIM_W;
	localparam int ZW         = biu_pkg::ZOOM_W;

	localparam logic [ZW:0]   ZMAX      = (ZW+1)'(MAX_ZOOM);
	localparam logic [DW-1:0] WMAX      = DW'(MAX_WIDTH);
	localparam logic [DW-1:0] HMAX      = DW'(MAX_HEIGHT);
	localparam logic [ZW-1:0] ZOOM_RST  = (MAX_ZOOM < 2) ? ZW'(MAX_ZOOM) : ZW'(2);
	localparam logic [DW-1:0] COLS_RST  = (MAX_WIDTH < 256) ? DW'(MAX_WIDTH) : DW'(256);
	localparam logic [DW-1:0] ROWS_RST  = (MAX_HEIGHT < 256) ? DW'(MAX_HEIGHT) : DW'(256);

	logic [ZW-1:0]  zoom_q, zoom_wr;
	logic [DW-1:0]  cols_q, rows_q, cols_wr, rows_wr, dim_raw;

	logic           adv;
	biu_pkg::item_t item_s1;

	logic [3:0][BANK_AW-1:0]        rd_addr;
	logic [3:0]                     wr_en;
	logic [BANK_AW-1:0]             wr_addr;
	logic [biu_pkg::PIX_W-1:0]      wr_data;
	logic [3:0][biu_pkg::PIX_W-1:0] bank_q;
	biu_pkg::tag_t                  tag;

	// config values are stored already clamped to their legal range
	always_comb begin
		dim_raw = DW'(cfg_wdata);
		if (cfg_wdata[ZW-1:0] == '0) begin
			zoom_wr = ZW'(1);
		end else if ((ZW+1)'(cfg_wdata[ZW-1:0]) > ZMAX) begin
			zoom_wr = ZMAX[ZW-1:0];
		end else begin
			zoom_wr = cfg_wdata[ZW-1:0];
		end
		if (dim_raw == '0) begin
			cols_wr = DW'(1);
		end else if (dim_raw > WMAX) begin
			cols_wr = WMAX;
		end else begin
			cols_wr = dim_raw;
		end
		if (dim_raw == '0) begin
			rows_wr = DW'(1);
		end else if (dim_raw > HMAX) begin
			rows_wr = HMAX;
		end else begin
			rows_wr = dim_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= ZOOM_RST;
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				biu_pkg::REG_ZOOM: zoom_q <= zoom_wr;
				biu_pkg::REG_COLS: cols_q <= cols_wr;
				biu_pkg::REG_ROWS: rows_q <= rows_wr;
				default: ;
			endcase
		end
	end

	// single pipeline enable: move on whenever the output register is free
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1.valid   <= req.valid;
			item_s1.cmd     <= req.cmd;
			item_s1.src_row <= req.src_row;
			item_s1.src_col <= req.src_col;
			item_s1.pixel   <= req.pixel_in;
			item_s1.out_row <= req.out_row;
			item_s1.out_col <= req.out_col;
		end
	end

	// coordinate split, range check, bank addresses and load writes
	biu_coord #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.ROW_W      (ROW_W),
		.COL_W      (COL_W),
		.BANK_AW    (BANK_AW)
	) u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.zoom    (zoom_q),
		.cols    (cols_q),
		.rows    (rows_q),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.tag     (tag)
	);

	// four parity banks, read data lines up with the blend entry stage
	for (genvar b = 0; b < 4; b++) begin : g_bank
		biu_ram #(
			.WIDTH (biu_pkg::PIX_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_en[b]),
			.waddr (wr_addr),
			.wdata (wr_data),
			.re    (adv),
			.raddr (rd_addr[b]),
			.rdata (bank_q[b])
		);
	end

	// weights, weighted sum, normalization and output register
	biu_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.tag         (tag),
		.bank_q      (bank_q),
		.out_valid   (rsp.valid),
		.pixel_out   (rsp.pixel_out),
		.range_error (rsp.range_error)
	);

	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("load word written to more than one bank");

	a_write_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en != '0) |-> adv)
		else $error("bank written while pipeline is stalled");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(item_s1))
		else $error("input stage moved during output stall");

	a_zoom_legal: assert property (@(posedge clk) disable iff (!arst_n)
		zoom_q != '0 && (ZW+1)'(zoom_q) <= ZMAX && cols_q != '0 && cols_q <= WMAX)
		else $error("stored config outside legal range");

endmodule

/* test/bilinear_image_upscaler_test.sv */
// ---------------------------------------------------------------------------
// bilinear_image_upscaler_test
// self-checking bench: loads small source images, requests zoomed pixels and
// compares each response word with a bilinear predictor kept in the bench
// ---------------------------------------------------------------------------
module bilinear_image_upscaler_test;

	localparam logic [biu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 12;

	typedef struct packed {
		logic                        cmd;
		logic [biu_pkg::SRC_W-1:0]   src_row;
		logic [biu_pkg::SRC_W-1:0]   src_col;
		logic [biu_pkg::PIX_W-1:0]   pixel;
		logic [biu_pkg::COORD_W-1:0] out_row;
		logic [biu_pkg::COORD_W-1:0] out_col;
	} word_t;

	typedef struct packed {
		logic [biu_pkg::PIX_W-1:0] pixel;
		logic                      range_err;
	} pix_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [biu_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [biu_pkg::CFG_W-1:0] cfg_wdata;

	biu_req_if req_ch();
	biu_rsp_if rsp_ch();

	bilinear_image_upscaler u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// bench copy of image and registers
	logic [biu_pkg::PIX_W-1:0] shadow_img [biu_pkg::MAX_WIDTH*biu_pkg::MAX_HEIGHT];
	logic [biu_pkg::ZOOM_W-1:0] zoom_reg;
	logic [biu_pkg::CFG_W-1:0] cols_reg, rows_reg;

	word_t pending_words[$];
	pix_t  expected_pix[$];

	int failures = 0;
	int cycles = 0;
	int n_loads = 0, n_reads = 0, n_oob = 0, n_checked = 0, n_phases = 0;
	logic taken = 0;
	int burst_left = 0, gap_left = 0;
	int ready_run = 0;
	logic ready_level = 1;
	logic hold_request = 0;
	int hold_count = 0;

	function automatic int eff_zoom();
		if (zoom_reg == 0) return 1;
		if (zoom_reg > biu_pkg::MAX_ZOOM) return biu_pkg::MAX_ZOOM;
		return zoom_reg;
	endfunction

	function automatic int eff_size(input logic [biu_pkg::CFG_W-1:0] v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// bilinear blend of the 2x2 neighbours, weights scaled by z, floor of sum / z^2
	function automatic pix_t blend_pixel(input word_t w);
		int z, rows, cols, y0, x0, y1, x1, fy, fx, gy, gx, sum, mw;
		pix_t r;
		mw = biu_pkg::MAX_WIDTH;
		z = eff_zoom();
		cols = eff_size(cols_reg, biu_pkg::MAX_WIDTH);
		rows = eff_size(rows_reg, biu_pkg::MAX_HEIGHT);
		r.pixel = '0;
		r.range_err = 1'b1;
		if (w.out_row >= rows * z || w.out_col >= cols * z) return r;
		y0 = w.out_row / z;
		fy = w.out_row % z;
		x0 = w.out_col / z;
		fx = w.out_col % z;
		y1 = (y0 + 1 < rows) ? y0 + 1 : rows - 1;
		x1 = (x0 + 1 < cols) ? x0 + 1 : cols - 1;
		gy = z - fy;
		gx = z - fx;
		sum = gy * gx * shadow_img[y0*mw+x0] + gy * fx * shadow_img[y0*mw+x1]
			+ fy * gx * shadow_img[y1*mw+x0] + fy * fx * shadow_img[y1*mw+x1];
		r.pixel = biu_pkg::PIX_W'(sum / (z * z));
		r.range_err = 1'b0;
		return r;
	endfunction

	// clock and the cycle limit
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// accepted request word: update the image copy or queue the expected pixel
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (pending_words[0].cmd == biu_pkg::CMD_LOAD) begin
				shadow_img[pending_words[0].src_row*biu_pkg::MAX_WIDTH
					+ pending_words[0].src_col] = pending_words[0].pixel;
				n_loads++;
			end else begin
				expected_pix.push_back(blend_pixel(pending_words[0]));
				n_reads++;
			end
			void'(pending_words.pop_front());
			taken = 1;
		end
	end

	// driver: bursts of random length, random gaps, some long gap-free stretches
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || taken)) begin
			taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.cmd <= pending_words[0].cmd;
				req_ch.src_row <= pending_words[0].src_row;
				req_ch.src_col <= pending_words[0].src_col;
				req_ch.pixel_in <= pending_words[0].pixel;
				req_ch.out_row <= pending_words[0].out_row;
				req_ch.out_col <= pending_words[0].out_col;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: runs of ready and stall, plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request && hold_count < 300) begin
				hold_count++;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (ready_run == 0) begin
					ready_level = ~ready_level;
					ready_run = ready_level ? $urandom_range(1, 30) : $urandom_range(1, 4);
				end else ready_run--;
				rsp_ch.ready <= ready_level;
			end
		end
	end

	// monitor: compare each response word with the oldest expected pixel
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_pix.size() == 0) begin
				$error("response word with nothing expected");
				failures++;
			end else begin
				if (rsp_ch.pixel_out !== expected_pix[0].pixel) begin
					$error("pixel_out expected %0d actual %0d",
						expected_pix[0].pixel, rsp_ch.pixel_out);
					failures++;
				end
				if (rsp_ch.range_error !== expected_pix[0].range_err) begin
					$error("range_error expected %0d actual %0d",
						expected_pix[0].range_err, rsp_ch.range_error);
					failures++;
				end
				void'(expected_pix.pop_front());
				n_checked++;
			end
		end
	end

	task automatic drain();
		while (pending_words.size() > 0 || expected_pix.size() > 0) @(posedge clk);
		// loads leave no response, so let the pipeline empty as well
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [biu_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= biu_pkg::CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			biu_pkg::REG_ZOOM: zoom_reg = biu_pkg::ZOOM_W'(val);
			biu_pkg::REG_COLS: cols_reg = biu_pkg::CFG_W'(val);
			biu_pkg::REG_ROWS: rows_reg = biu_pkg::CFG_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_image(input int z, input int cols, input int rows);
		drain();
		write_reg(biu_pkg::REG_ZOOM, z);
		write_reg(biu_pkg::REG_COLS, cols);
		write_reg(biu_pkg::REG_ROWS, rows);
		n_phases++;
	endtask

	task automatic push_load(input int r, input int c, input int p);
		word_t w;
		w.cmd = biu_pkg::CMD_LOAD;
		w.src_row = biu_pkg::SRC_W'(r);
		w.src_col = biu_pkg::SRC_W'(c);
		w.pixel = biu_pkg::PIX_W'(p);
		w.out_row = biu_pkg::COORD_W'($urandom);
		w.out_col = biu_pkg::COORD_W'($urandom);
		pending_words.push_back(w);
	endtask

	task automatic push_read(input int r, input int c);
		word_t w;
		w.cmd = biu_pkg::CMD_READ;
		w.src_row = biu_pkg::SRC_W'($urandom);
		w.src_col = biu_pkg::SRC_W'($urandom);
		w.pixel = biu_pkg::PIX_W'($urandom);
		w.out_row = biu_pkg::COORD_W'(r);
		w.out_col = biu_pkg::COORD_W'(c);
		pending_words.push_back(w);
	endtask

	// fill every pixel the current size can reach, extremes mixed in
	task automatic fill_image(input int rows, input int cols);
		int r, c, p;
		for (r = 0; r < rows; r++)
			for (c = 0; c < cols; c++) begin
				case ($urandom_range(0, 5))
					0: p = 0;
					1: p = 255;
					default: p = $urandom_range(0, 255);
				endcase
				push_load(r, c, p);
			end
	endtask

	// corners, last row/column, just-outside and far-outside requests
	task automatic edge_reads();
		int z, rows, cols;
		z = eff_zoom();
		rows = eff_size(rows_reg, biu_pkg::MAX_HEIGHT) * z;
		cols = eff_size(cols_reg, biu_pkg::MAX_WIDTH) * z;
		push_read(0, 0);
		push_read(rows - 1, cols - 1);
		push_read(rows - 1, 0);
		push_read(0, cols - 1);
		push_read(rows, 0);
		push_read(0, cols);
		push_read(2047, 2047);
	endtask

	initial begin
		int k, z, rows, cols, er, ec;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 0;
		req_ch.cmd = 0;
		req_ch.src_row = '0;
		req_ch.src_col = '0;
		req_ch.pixel_in = '0;
		req_ch.out_row = '0;
		req_ch.out_col = '0;
		rsp_ch.ready = 0;
		zoom_reg = 4'd2;
		cols_reg = 9'd256;
		rows_reg = 9'd256;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: only a 3x3 corner is loaded; in-range reads stay inside it, the rest fall out of range
		fill_image(3, 3);
		push_read(0, 0);
		push_read(3, 3);
		push_read(1, 2);
		push_read(512, 0);
		push_read(0, 512);
		push_read(2047, 2047);

		// zero fields act as one, the unused index is a no-op
		set_image(0, 0, 0);
		write_reg(REG_UNUSED, 511);
		fill_image(1, 1);
		edge_reads();
		// oversized zoom, full width single row
		set_image(15, 511, 1);
		fill_image(1, 256);
		edge_reads();
		push_read(0, 1000);
		// unit zoom, full height single column
		set_image(1, 1, 256);
		fill_image(256, 1);
		edge_reads();
		push_read(200, 0);

		// random phases: small images, in-range reads with reloads and noise
		while (n_loads + n_reads + pending_words.size() < 1750) begin
			z = $urandom_range(0, 15);
			cols = $urandom_range(1, 12);
			rows = $urandom_range(1, 12);
			set_image(z, cols, rows);
			if (n_phases == 8) hold_request = 1;
			fill_image(rows, cols);
			ec = eff_zoom() * cols;
			er = eff_zoom() * rows;
			for (k = 0; k < 90; k++) begin
				case ($urandom_range(0, 9))
					0, 1: push_load($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
						$urandom_range(0, 255));
					2: push_read($urandom_range(0, 2047), $urandom_range(0, 2047));
					default: push_read($urandom_range(0, er - 1), $urandom_range(0, ec - 1));
				endcase
			end
			edge_reads();
		end

		drain();
		$display("%0d loads and %0d pixel requests over %0d image settings",
			n_loads, n_reads, n_phases);
		$display("%0d response words checked, %0d mismatches", n_checked, failures);
		if (failures == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/core/biu_pkg.sv
rtl/core/biu_if.sv
rtl/core/biu_ram.sv
rtl/core/biu_coord.sv
rtl/core/biu_blend.sv
rtl/core/bilinear_image_upscaler.sv
test/bilinear_image_upscaler_test.sv
